/* rtl/core/eidg_pkg.sv */
package eidg_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int NUM_STAGES = 2 * NUM_ROUNDS + 1;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_EXPONENT = 2'd2;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] beacon_time;
        logic [3:0]  exponent;
    } item_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input block_t b, input int idx);
        get_byte = b[127 - 8 * idx -: 8];
    endfunction

    function automatic block_t next_round_key(input block_t k, input logic [3:0] round);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ RCON[round], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t n;
        n = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                n[127 - 8 * (c * 4 + j) -: 8] = SBOX[get_byte(s, ((c + j) % 4) * 4 + j)];
            end
        end
        sub_shift = n;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t n;
        logic [7:0] a0, a1, a2, a3, t;
        n = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, c * 4);
            a1 = get_byte(s, c * 4 + 1);
            a2 = get_byte(s, c * 4 + 2);
            a3 = get_byte(s, c * 4 + 3);
            t = a0 ^ a1 ^ a2 ^ a3;
            n[127 - 32 * c -: 32] = {a0 ^ t ^ xtime(a0 ^ a1), a1 ^ t ^ xtime(a1 ^ a2),
                                     a2 ^ t ^ xtime(a2 ^ a3), a3 ^ t ^ xtime(a3 ^ a0)};
        end
        mix_columns = n;
    endfunction

endpackage

/* rtl/core/eidg_aes_pipe.sv */
module eidg_aes_pipe
    import eidg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  item_ctl_t ctl_in,
    input  block_t    key_in,
    input  block_t    text_in,
    output item_ctl_t ctl_out,
    output block_t    text_out
);

    logic        valid_reg [NUM_STAGES];
    logic [31:0] time_reg  [NUM_STAGES];
    logic [3:0]  exp_reg   [NUM_STAGES];
    block_t      state_reg [NUM_STAGES];
    block_t      key_reg   [NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= ctl_in.valid;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i - 1];
            end
        end
    end

    // stage 0: whitening; odd stage: sub/shift/key step; even stage: mix and add key (last round: add key only)
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            time_reg[0]  <= ctl_in.beacon_time;
            exp_reg[0]   <= ctl_in.exponent;
            state_reg[0] <= text_in ^ key_in;
            key_reg[0]   <= key_in;
            for (int r = 0; r < NUM_ROUNDS; r++)
            begin
                time_reg[2 * r + 1]  <= time_reg[2 * r];
                exp_reg[2 * r + 1]   <= exp_reg[2 * r];
                state_reg[2 * r + 1] <= sub_shift(state_reg[2 * r]);
                key_reg[2 * r + 1]   <= next_round_key(key_reg[2 * r], 4'(r));
                time_reg[2 * r + 2]  <= time_reg[2 * r + 1];
                exp_reg[2 * r + 2]   <= exp_reg[2 * r + 1];
                key_reg[2 * r + 2]   <= key_reg[2 * r + 1];
                if (r < NUM_ROUNDS - 1)
                begin
                    state_reg[2 * r + 2] <= mix_columns(state_reg[2 * r + 1])
                                            ^ key_reg[2 * r + 1];
                end
                else
                begin
                    state_reg[2 * r + 2] <= state_reg[2 * r + 1] ^ key_reg[2 * r + 1];
                end
            end
        end
    end

    assign ctl_out  = '{valid:       valid_reg[NUM_STAGES - 1],
                        beacon_time: time_reg[NUM_STAGES - 1],
                        exponent:    exp_reg[NUM_STAGES - 1]};
    assign text_out = state_reg[NUM_STAGES - 1];

endmodule

/* rtl/core/ephemeral_id_generator_core.sv */
// Structure: two AES-128 pipelines in series between input accept and output valid.
// Throughput: one item per cycle while not stalled; each AES round is split over two register stages.
// Stall: the whole pipeline holds while the output item waits and is not taken.
// Reset: rst_n asynchronous active low clears all valid bits and the config registers to zero.
module ephemeral_id_generator_core
    import eidg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] beacon_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] eid_high,
    output logic [63:0] eid_low,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [3:0]  exponent_reg;

    logic      advance;
    item_ctl_t ctl_a_in, ctl_a_out, ctl_b_out;
    block_t    tk_text, tk_out, eid_text, eid_out;
    logic [31:0] time_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            exponent_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_EXPONENT: exponent_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    assign ctl_a_in = '{valid: in_valid, beacon_time: beacon_time, exponent: exponent_reg};
    assign tk_text  = {88'd0, 8'hff, 16'd0, beacon_time[31:16]};

    eidg_aes_pipe u_tk_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .ctl_in   (ctl_a_in),
        .key_in   ({key_high_reg, key_low_reg}),
        .text_in  (tk_text),
        .ctl_out  (ctl_a_out),
        .text_out (tk_out)
    );

    assign time_q   = ctl_a_out.beacon_time & ~((32'd1 << ctl_a_out.exponent) - 32'd1);
    assign eid_text = {88'd0, 4'd0, ctl_a_out.exponent, time_q};

    eidg_aes_pipe u_eid_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .ctl_in   (ctl_a_out),
        .key_in   (tk_out),
        .text_in  (eid_text),
        .ctl_out  (ctl_b_out),
        .text_out (eid_out)
    );

    assign out_valid = ctl_b_out.valid;
    assign eid_high  = eid_out[127:64];
    assign eid_low   = eid_out[63:0];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(eid_high) && $stable(eid_low))
        else $error("result changed while stalled");
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");
    a_exp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(exponent_reg))
        else $error("exponent changed without write");

endmodule
